// ===== src/fixed_point_alu_unit_defines.svh =====
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_NORESET(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_NORESET(label, clk, prop, msg)
`endif
`endif

// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int QIDX_W    = 1;
    localparam int QDEPTH    = 2;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_GT  = 4'd4, CMD_LT  = 4'd5, CMD_GE  = 4'd6, CMD_LE  = 4'd7,
        CMD_EQ  = 4'd8, CMD_NE  = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
        CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_ITOF = 4'd14, CMD_FTOI = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } cls_t;

    // Classified request handed from the front end to the execution end.
    typedef struct packed {
        cls_t                     cls;
        logic [DATA_W-1:0]        value;   // finished result for simple requests
        logic                     cmp;
        logic                     dz;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } req_t;
endpackage
`default_nettype wire

// ===== src/fixed_point_alu_unit.sv =====
// One request per cycle is accepted sustained while the result buffer is not full.
// Every opcode takes the same path through the front queue and the pipelined
// restoring divider, one quotient bit per stage; results leave in order.
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU: classifying front end, queue, pipelined execution end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_unit_defines.svh"
module fixed_point_alu_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [3:0]                         s_cmd,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]  s_operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]  s_operand_b,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fpa_pkg::DATA_W-1:0]       m_result_value,
    output logic                                    m_compare_true,
    output logic                                    m_divide_by_zero
);
    fpa_pkg::req_t q_data;
    logic q_valid, q_ready;

    fpa_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_operand_a, .s_operand_b,
        .q_data, .q_valid, .q_ready
    );

    fpa_back u_back (
        .aclk, .aresetn, .q_data, .q_valid, .q_ready,
        .m_valid, .m_ready, .m_result_value, .m_compare_true, .m_divide_by_zero
    );

    `FPA_ASSERT_IMPL(a_cmp_no_value, aclk, aresetn,
        m_valid && m_compare_true |-> m_result_value == '0, "compare carries a value")
    `FPA_ASSERT_IMPL(a_dz_flags, aclk, aresetn,
        m_valid && m_divide_by_zero |-> !m_compare_true && m_result_value == '0,
        "divide by zero result malformed")
    `FPA_ASSERT_IMPL(a_out_hold, aclk, aresetn,
        $past(m_valid && !m_ready) |-> m_valid && $stable(m_result_value),
        "stalled result changed")
endmodule
`default_nettype wire

// ===== src/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Accepts requests, classifies them and finishes the simple operations.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [3:0]                           s_cmd,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]    s_operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]    s_operand_b,
    output fpa_pkg::req_t                             q_data,
    output logic                                      q_valid,
    input  wire logic                                 q_ready
);
    fpa_pkg::req_t req_next;
    fpa_pkg::req_t q_reg [fpa_pkg::QDEPTH];
    logic [fpa_pkg::QIDX_W-1:0] wr_reg, rd_reg;
    logic [fpa_pkg::QIDX_W:0]   cnt_reg;
    logic push, pop;
    logic lt, gt;

    assign lt = s_operand_a < s_operand_b;
    assign gt = s_operand_a > s_operand_b;

    always_comb begin
        req_next = '0;
        req_next.a = s_operand_a;
        req_next.b = s_operand_b;
        req_next.cls = fpa_pkg::CLS_SIMPLE;
        unique case (fpa_pkg::cmd_t'(s_cmd))
            fpa_pkg::CMD_ADD: req_next.value = s_operand_a + s_operand_b;
            fpa_pkg::CMD_SUB: req_next.value = s_operand_a - s_operand_b;
            fpa_pkg::CMD_MUL: req_next.cls = fpa_pkg::CLS_MUL;
            fpa_pkg::CMD_DIV: begin
                if (s_operand_b == '0) begin
                    req_next.dz = 1'b1;
                end else begin
                    req_next.cls = fpa_pkg::CLS_DIV;
                end
            end
            fpa_pkg::CMD_GT: req_next.cmp = gt;
            fpa_pkg::CMD_LT: req_next.cmp = lt;
            fpa_pkg::CMD_GE: req_next.cmp = !lt;
            fpa_pkg::CMD_LE: req_next.cmp = !gt;
            fpa_pkg::CMD_EQ: req_next.cmp = s_operand_a == s_operand_b;
            fpa_pkg::CMD_NE: req_next.cmp = s_operand_a != s_operand_b;
            fpa_pkg::CMD_MIN: req_next.value = lt ? s_operand_a : s_operand_b;
            fpa_pkg::CMD_MAX: req_next.value = gt ? s_operand_a : s_operand_b;
            fpa_pkg::CMD_INC: req_next.value = s_operand_a + 32'sd1;
            fpa_pkg::CMD_DEC: req_next.value = s_operand_a - 32'sd1;
            fpa_pkg::CMD_ITOF: req_next.value = s_operand_a <<< fpa_pkg::FRAC_BITS;
            fpa_pkg::CMD_FTOI: req_next.value = s_operand_a >>> fpa_pkg::FRAC_BITS;
            default: req_next.value = '0;
        endcase
    end

    // Two-entry queue decouples the front from the execution end.
    assign s_ready = cnt_reg != (fpa_pkg::QIDX_W+1)'(fpa_pkg::QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_data  = q_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (fpa_pkg::QIDX_W+1)'(push) - (fpa_pkg::QIDX_W+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= req_next;
    end
endmodule
`default_nettype wire

// ===== src/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Execution end: one shared pipeline with the multiplier and radix-2 divider, result skid.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire fpa_pkg::req_t                  q_data,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [fpa_pkg::DATA_W-1:0]   m_result_value,
    output logic                                m_compare_true,
    output logic                                m_divide_by_zero
);
    localparam int NW    = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS;
    localparam int STG   = NW + 2;  // sign stage, NW bit steps, fixup stage
    localparam int PW    = 2 * fpa_pkg::DATA_W;

    typedef struct packed {
        logic                 vld;
        fpa_pkg::cls_t        cls;
        logic [fpa_pkg::DATA_W-1:0] value;
        logic                 cmp;
        logic                 dz;
        logic                 neg;
        logic [NW-1:0]        quo;
        logic [NW:0]          rem;
        logic [fpa_pkg::DATA_W-1:0] dvs;
        logic [PW-1:0]        prod;
    } stg_t;

    stg_t pipe_reg [STG];
    stg_t tail;
    logic adv;
    logic [fpa_pkg::DATA_W-1:0] res_q [4];
    logic [3:0] cmp_q, dz_q;
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic push, pop, take;

    // The whole pipeline holds while the output buffer is full.
    assign adv     = cnt_reg != 3'd4;
    assign q_ready = adv;
    assign take    = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0].vld   <= take;
            pipe_reg[0].cls   <= q_data.cls;
            pipe_reg[0].value <= q_data.value;
            pipe_reg[0].cmp   <= q_data.cmp;
            pipe_reg[0].dz    <= q_data.dz;
            pipe_reg[0].neg   <= q_data.a[fpa_pkg::DATA_W-1] ^ q_data.b[fpa_pkg::DATA_W-1];
            pipe_reg[0].quo   <= NW'($unsigned(q_data.a[fpa_pkg::DATA_W-1] ? -q_data.a
                                                                          : q_data.a))
                                 << fpa_pkg::FRAC_BITS;
            pipe_reg[0].rem   <= '0;
            pipe_reg[0].dvs   <= q_data.b[fpa_pkg::DATA_W-1] ? -q_data.b : q_data.b;
            pipe_reg[0].prod  <= PW'(q_data.a) * PW'(q_data.b);
        end
        if (!aresetn) pipe_reg[0].vld <= 1'b0;
    end

    // One restoring division step per stage; the product just rides along.
    for (genvar i = 1; i < STG - 1; i++) begin : g_div
        logic [NW:0] r_sh;
        logic [NW:0] r_sub;
        assign r_sh  = {pipe_reg[i-1].rem[NW-1:0], pipe_reg[i-1].quo[NW-1]};
        assign r_sub = r_sh - (NW+1)'(pipe_reg[i-1].dvs);
        always_ff @(posedge aclk) begin
            if (adv) begin
                pipe_reg[i] <= pipe_reg[i-1];
                if (pipe_reg[i-1].cls == fpa_pkg::CLS_DIV) begin
                    pipe_reg[i].rem <= r_sub[NW] ? r_sh : r_sub;
                    pipe_reg[i].quo <= {pipe_reg[i-1].quo[NW-2:0], !r_sub[NW]};
                end
            end
            if (!aresetn) pipe_reg[i].vld <= 1'b0;
        end
    end

    always_comb begin
        tail = pipe_reg[STG-2];
        unique case (tail.cls)
            fpa_pkg::CLS_MUL: tail.value =
                fpa_pkg::DATA_W'(signed'(tail.prod) >>> fpa_pkg::FRAC_BITS);
            fpa_pkg::CLS_DIV: tail.value =
                fpa_pkg::DATA_W'(tail.neg ? -tail.quo : tail.quo);
            default: tail.value = pipe_reg[STG-2].value;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) pipe_reg[STG-1] <= tail;
        if (!aresetn) pipe_reg[STG-1].vld <= 1'b0;
    end

    assign push = pipe_reg[STG-1].vld && adv;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_q[wr_reg] <= pipe_reg[STG-1].value;
            cmp_q[wr_reg] <= pipe_reg[STG-1].cmp;
            dz_q[wr_reg]  <= pipe_reg[STG-1].dz;
        end
    end

    assign m_valid          = cnt_reg != '0;
    assign m_result_value   = res_q[rd_reg];
    assign m_compare_true   = cmp_q[rd_reg];
    assign m_divide_by_zero = dz_q[rd_reg];
endmodule
`default_nettype wire
